FILE: rtl/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants for the dual-mode PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int DATA_W  = 16;
  localparam int ERR_W   = 17;
  localparam int GAIN_W  = 32;
  localparam int BOUND_W = 31;
  localparam int INTEG_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int SUM_W   = 64;
  localparam int FRAC_W  = 16;

  localparam int OP_P_W = 18;
  localparam int OP_D_W = 19;
  localparam int PR_P_W = GAIN_W + OP_P_W;
  localparam int PR_I_W = GAIN_W + INTEG_W;
  localparam int PR_D_W = GAIN_W + OP_D_W;

  localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_KP    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KI    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KD    = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOUND = 3'd4;
  localparam logic [IDX_W-1:0] REG_OMAX  = 3'd5;
  localparam logic [IDX_W-1:0] REG_OMIN  = 3'd6;

  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 16'sh8000;

  // multiplier operands: p * kp, i * ki, d * kd
  typedef struct packed {
    logic signed [OP_P_W-1:0]  p;
    logic signed [INTEG_W-1:0] i;
    logic signed [OP_D_W-1:0]  d;
  } op_t;

  typedef struct packed {
    logic signed [PR_P_W-1:0] p;
    logic signed [PR_I_W-1:0] i;
    logic signed [PR_D_W-1:0] d;
  } prod_t;

endpackage

FILE: rtl/pid_front.sv
// ----------------------------------------------------------------------------
// pid_front
// Error, integral and error history; selects multiplier operands by mode.
// ----------------------------------------------------------------------------
module pid_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 mode,
  input  logic [pid_pkg::BOUND_W-1:0]          bound,
  input  logic                                 in_vld,
  output logic                                 in_rdy,
  input  logic signed [pid_pkg::DATA_W-1:0]    setpoint,
  input  logic signed [pid_pkg::DATA_W-1:0]    measured,
  output logic                                 op_vld,
  input  logic                                 op_rdy,
  output pid_pkg::op_t                         op
);

  logic                                   vld_r;
  pid_pkg::op_t                           op_r, op_nxt;
  logic signed [pid_pkg::INTEG_W-1:0]     integ_r, integ_nxt;
  logic signed [pid_pkg::ERR_W-1:0]       last_r, last_nxt;
  logic signed [pid_pkg::ERR_W-1:0]       prev_r, prev_nxt;
  logic signed [pid_pkg::ERR_W-1:0]       err;
  logic signed [pid_pkg::OP_P_W-1:0]      d1;
  logic signed [pid_pkg::OP_D_W-1:0]      d2;
  logic signed [pid_pkg::INTEG_W:0]       acc, bnd;
  logic                                   take;

  assign in_rdy = !vld_r || op_rdy;
  assign take   = in_vld && in_rdy;

  always_comb begin
    err = pid_pkg::ERR_W'(setpoint) - pid_pkg::ERR_W'(measured);
    d1  = pid_pkg::OP_P_W'(err) - pid_pkg::OP_P_W'(last_r);
    d2  = pid_pkg::OP_D_W'(err) - (pid_pkg::OP_D_W'(last_r) <<< 1)
        + pid_pkg::OP_D_W'(prev_r);
    acc = (pid_pkg::INTEG_W+1)'(integ_r) + (pid_pkg::INTEG_W+1)'(err);
    bnd = $signed({2'b00, bound});
    integ_nxt = integ_r;
    prev_nxt  = prev_r;
    last_nxt  = err;
    if (mode == pid_pkg::MODE_POS) begin
      if (acc > bnd) begin
        integ_nxt = pid_pkg::INTEG_W'(bnd);
      end else if (acc < -bnd) begin
        integ_nxt = pid_pkg::INTEG_W'(-bnd);
      end else begin
        integ_nxt = pid_pkg::INTEG_W'(acc);
      end
      op_nxt.p = pid_pkg::OP_P_W'(err);
      op_nxt.i = integ_nxt;
      op_nxt.d = pid_pkg::OP_D_W'(d1);
    end else begin
      prev_nxt = last_r;
      op_nxt.p = d1;
      op_nxt.i = pid_pkg::INTEG_W'(err);
      op_nxt.d = d2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      integ_r <= '0;
      last_r  <= '0;
      prev_r  <= '0;
    end else begin
      if (in_rdy) begin
        vld_r <= in_vld;
      end
      if (take) begin
        integ_r <= integ_nxt;
        last_r  <= last_nxt;
        prev_r  <= prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= op_nxt;
    end
  end

  assign op_vld = vld_r;
  assign op     = op_r;

endmodule

FILE: rtl/pid_mult.sv
// ----------------------------------------------------------------------------
// pid_mult
// Three parallel gain multipliers with registered products.
// ----------------------------------------------------------------------------
module pid_mult (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [pid_pkg::GAIN_W-1:0]    kp_gain,
  input  logic signed [pid_pkg::GAIN_W-1:0]    ki_gain,
  input  logic signed [pid_pkg::GAIN_W-1:0]    kd_gain,
  input  logic                                 op_vld,
  output logic                                 op_rdy,
  input  pid_pkg::op_t                         op,
  output logic                                 prod_vld,
  input  logic                                 prod_rdy,
  output pid_pkg::prod_t                       prod
);

  logic           vld_r;
  pid_pkg::prod_t prod_r, prod_nxt;

  assign op_rdy = !vld_r || prod_rdy;

  always_comb begin
    prod_nxt.p = pid_pkg::PR_P_W'(kp_gain) * pid_pkg::PR_P_W'(op.p);
    prod_nxt.i = pid_pkg::PR_I_W'(ki_gain) * pid_pkg::PR_I_W'(op.i);
    prod_nxt.d = pid_pkg::PR_D_W'(kd_gain) * pid_pkg::PR_D_W'(op.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (op_rdy) begin
      vld_r <= op_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (op_vld && op_rdy) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_vld = vld_r;
  assign prod     = prod_r;

endmodule

FILE: rtl/pid_out.sv
// ----------------------------------------------------------------------------
// pid_out
// Sums the products, truncates Q16.16 toward zero and clamps the drive.
// ----------------------------------------------------------------------------
module pid_out (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [pid_pkg::DATA_W-1:0]    out_max,
  input  logic signed [pid_pkg::DATA_W-1:0]    out_min,
  input  logic                                 prod_vld,
  output logic                                 prod_rdy,
  input  pid_pkg::prod_t                       prod,
  output logic                                 res_vld,
  input  logic                                 res_rdy,
  output logic signed [pid_pkg::DATA_W-1:0]    drive,
  output logic                                 clamped
);

  localparam int Q_W = pid_pkg::SUM_W - pid_pkg::FRAC_W;

  logic                                 sum_vld_r;
  logic signed [pid_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic                                 sum_rdy;
  logic                                 res_vld_r;
  logic signed [pid_pkg::DATA_W-1:0]    drive_r, drive_nxt;
  logic                                 clamped_r, clamped_nxt;
  logic signed [Q_W-1:0]                q;

  assign prod_rdy = !sum_vld_r || sum_rdy;
  assign sum_rdy  = !res_vld_r || res_rdy;

  always_comb begin
    sum_nxt = pid_pkg::SUM_W'(prod.p) + pid_pkg::SUM_W'(prod.i)
            + pid_pkg::SUM_W'(prod.d);
  end

  // round toward zero: bump floor for negative values with a fraction
  always_comb begin
    q = Q_W'(sum_r >>> pid_pkg::FRAC_W);
    if (sum_r[pid_pkg::SUM_W-1] && (|sum_r[pid_pkg::FRAC_W-1:0])) begin
      q = q + Q_W'(1);
    end
    clamped_nxt = 1'b1;
    if (q < Q_W'(out_min)) begin
      drive_nxt = out_min;
    end else if (q > Q_W'(out_max)) begin
      drive_nxt = out_max;
    end else begin
      drive_nxt   = pid_pkg::DATA_W'(q);
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (prod_rdy) begin
        sum_vld_r <= prod_vld;
      end
      if (sum_rdy) begin
        res_vld_r <= sum_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_vld && prod_rdy) begin
      sum_r <= sum_nxt;
    end
    if (sum_vld_r && sum_rdy) begin
      drive_r   <= drive_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign res_vld = res_vld_r;
  assign drive   = drive_r;
  assign clamped = clamped_r;

endmodule

FILE: rtl/pid_controller_dual_mode.sv
// ----------------------------------------------------------------------------
// pid_controller_dual_mode
// Positional / incremental PID controller with Q16.16 gains and clamped drive.
//
//   port group   dir   beat contents
//   in_*         in    setpoint, measured (signed 16 bit)
//   out_*        out   drive (signed 16 bit), clamped flag
//   cfg_*        in    register write: index, data
//
// Four register stages: state/operands, products, sum, result.
// One beat per cycle sustained while out_ready stays high; out_valid rises when the beat reaches the result register.
// Integral and error history update when an input beat is accepted.
// Sync active-low reset clears state, valids, mode, gains and bound; output limits reset to 7FFF / 8000.
// A stalled result holds its stage; empty stages upstream keep filling.
// ----------------------------------------------------------------------------
module pid_controller_dual_mode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pid_pkg::DATA_W-1:0]    in_setpoint,
  input  logic signed [pid_pkg::DATA_W-1:0]    in_measured,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pid_pkg::DATA_W-1:0]    out_drive,
  output logic                                 out_clamped,
  input  logic                                 cfg_we,
  input  logic [pid_pkg::IDX_W-1:0]            cfg_idx,
  input  logic [pid_pkg::CFG_W-1:0]            cfg_wdata
);

  logic                                 mode_r;
  logic signed [pid_pkg::GAIN_W-1:0]    kp_r, ki_r, kd_r;
  logic [pid_pkg::BOUND_W-1:0]          bound_r;
  logic signed [pid_pkg::DATA_W-1:0]    out_max_r, out_min_r;

  logic           op_vld, op_rdy;
  pid_pkg::op_t   op;
  logic           prod_vld, prod_rdy;
  pid_pkg::prod_t prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pid_pkg::MODE_POS;
      kp_r      <= '0;
      ki_r      <= '0;
      kd_r      <= '0;
      bound_r   <= '0;
      out_max_r <= pid_pkg::OUT_MAX_RST;
      out_min_r <= pid_pkg::OUT_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pid_pkg::REG_MODE:  mode_r    <= cfg_wdata[0];
        pid_pkg::REG_KP:    kp_r      <= $signed(cfg_wdata);
        pid_pkg::REG_KI:    ki_r      <= $signed(cfg_wdata);
        pid_pkg::REG_KD:    kd_r      <= $signed(cfg_wdata);
        pid_pkg::REG_BOUND: bound_r   <= cfg_wdata[pid_pkg::BOUND_W-1:0];
        pid_pkg::REG_OMAX:  out_max_r <= $signed(cfg_wdata[pid_pkg::DATA_W-1:0]);
        pid_pkg::REG_OMIN:  out_min_r <= $signed(cfg_wdata[pid_pkg::DATA_W-1:0]);
        default: ;
      endcase
    end
  end

  pid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .bound    (bound_r),
    .in_vld   (in_valid),
    .in_rdy   (in_ready),
    .setpoint (in_setpoint),
    .measured (in_measured),
    .op_vld   (op_vld),
    .op_rdy   (op_rdy),
    .op       (op)
  );

  pid_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .kp_gain  (kp_r),
    .ki_gain  (ki_r),
    .kd_gain  (kd_r),
    .op_vld   (op_vld),
    .op_rdy   (op_rdy),
    .op       (op),
    .prod_vld (prod_vld),
    .prod_rdy (prod_rdy),
    .prod     (prod)
  );

  pid_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_max  (out_max_r),
    .out_min  (out_min_r),
    .prod_vld (prod_vld),
    .prod_rdy (prod_rdy),
    .prod     (prod),
    .res_vld  (out_valid),
    .res_rdy  (out_ready),
    .drive    (out_drive),
    .clamped  (out_clamped)
  );

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |-> (out_drive == out_max_r || out_drive == out_min_r))
    else $error("clamped beat not at a limit");

  a_unclamped_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_clamped && (out_min_r <= out_max_r)
      |-> (out_drive >= out_min_r && out_drive <= out_max_r))
    else $error("unclamped beat outside limits");

  a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !op_vld && !prod_vld && !out_valid |-> in_ready)
    else $error("empty pipeline not accepting");

endmodule
